// ===== rtl/sscb_pkg.sv =====
// Shared constants and codes for the scaled sprite column blitter.
package sscb_pkg;

   localparam int SOURCE_DEPTH = 4096;

   // request commands
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
   localparam logic [2:0] REG_LINE_PITCH    = 3'd4;
   localparam logic [2:0] REG_TRANSPARENT   = 3'd5;
   localparam logic [2:0] REG_SCALE_WIDTH   = 3'd6;
   localparam logic [2:0] REG_SCALE_HEIGHT  = 3'd7;

   // register reset values
   localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd320;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd200;
   localparam logic [11:0] LINE_PITCH_RESET    = 12'd320;
   localparam logic [9:0]  SCALE_WIDTH_RESET   = 10'd1;
   localparam logic [9:0]  SCALE_HEIGHT_RESET  = 10'd1;

   // fetch stage to pixel stage
   typedef struct packed {
      logic        write_cand;
      logic [11:0] dx;
      logic [11:0] dy;
      logic        error;
      logic        done;
   } fetch_type;

endpackage

// ===== rtl/sscb_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sscb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sscb_pkg::SOURCE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/scaled_sprite_column_blit.sv =====
// Top level of the scaled sprite column blitter.
//
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     tuser command, tdata offset_step, source_byte
// rsp      out        rsp_tvalid/tready     tuser pixel_write, tdata address/color/error,
//                                           tlast frame_done
// csr      in         csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// One request per cycle unless a stalled rsp side holds req_tready low; each request gives one response.
// Fetch stage: offset accumulate, range check, clip and source RAM read.
// Pixel stage, into the response register: transparency test and the row*pitch+column multiply-add.
// Reset is synchronous; loaded bytes and their count survive a clear request.
// A stalled rsp side backs up through two registers before req_tready drops.
module scaled_sprite_column_blit #(
   parameter int SOURCE_DEPTH = sscb_pkg::SOURCE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [39:0] req_tdata,   // offset_step[31:0], source_byte[39:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // pixel_write
   output logic [39:0] rsp_tdata,   // pixel_address[23:0], pixel_color[31:24], error[32]
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(SOURCE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(SOURCE_DEPTH);

   // configuration
   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [11:0] screen_width_ff, screen_height_ff, line_pitch_ff;
   logic [7:0]  transparent_ff;
   logic [9:0]  scale_width_ff, scale_height_ff;

   // walk state
   logic [CW-1:0] loaded_ff, loaded_in;
   logic [AW-1:0] offset_ff, offset_in;
   logic [9:0]    row_ff, row_in;
   logic [9:0]    column_ff, column_in;
   logic          failed_ff, failed_in;
   logic          finished_ff, finished_in;

   // pipeline
   logic                 fetch_valid_ff;
   sscb_pkg::fetch_type  fetch_ff, fetch_in;
   logic                 rsp_valid_ff;
   logic                 write_ff;
   logic [23:0]          addr_ff;
   logic [7:0]           color_ff;
   logic                 error_ff;
   logic                 done_ff;

   logic        accept, out_free, fetch_move;
   logic [1:0]  command;
   logic [31:0] offset_step;
   logic [7:0]  source_byte;
   logic        is_load, is_clear, step_live, pitch_ok, reading, out_of_range, visible;
   logic [33:0] base_ext, sum;
   logic signed [16:0] dx, dy;
   logic [7:0]  ram_data;
   logic [23:0] product;
   logic        pixel_write;

   assign csr_ready = 1'b1;

   assign command     = req_tuser;
   assign offset_step = req_tdata[31:0];
   assign source_byte = req_tdata[39:32];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fetch_move = fetch_valid_ff && out_free;
   assign req_tready = !fetch_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign is_load   = (command == sscb_pkg::CMD_LOAD);
   assign is_clear  = (command == sscb_pkg::CMD_CLEAR);
   assign step_live = (command == sscb_pkg::CMD_STEP) && !failed_ff && !finished_ff;
   assign pitch_ok  = (line_pitch_ff >= screen_width_ff);
   assign reading   = (row_ff < scale_height_ff);

   // the first increment of a column replaces the offset
   assign base_ext = (row_ff == 10'd0) ? 34'd0 : 34'(offset_ff);
   assign sum      = base_ext + {{2{offset_step[31]}}, offset_step};
   assign out_of_range = sum[33] || (sum[32:0] >= 33'(loaded_ff));

   assign dx = $signed({origin_x_ff[15], origin_x_ff}) + $signed({7'd0, column_ff});
   assign dy = $signed({origin_y_ff[15], origin_y_ff}) + $signed({7'd0, row_ff});
   assign visible = !dx[16] && (dx[15:0] < {4'd0, screen_width_ff})
                 && !dy[16] && (dy[15:0] < {4'd0, screen_height_ff});

   always_comb begin
      loaded_in   = loaded_ff;
      offset_in   = offset_ff;
      row_in      = row_ff;
      column_in   = column_ff;
      failed_in   = failed_ff;
      finished_in = finished_ff;
      fetch_in.write_cand = 1'b0;
      fetch_in.dx   = dx[11:0];
      fetch_in.dy   = dy[11:0];
      fetch_in.done = 1'b0;
      if (is_load) begin
         if (loaded_ff != FULL_COUNT) begin
            loaded_in = loaded_ff + CW'(1);
         end
      end else if (is_clear) begin
         offset_in   = '0;
         row_in      = '0;
         column_in   = '0;
         failed_in   = 1'b0;
         finished_in = 1'b0;
      end else if (step_live) begin
         if (!pitch_ok) begin
            failed_in = 1'b1;
         end else if (reading) begin
            if (out_of_range) begin
               failed_in = 1'b1;
            end else begin
               offset_in = sum[AW-1:0];
               row_in    = row_ff + 10'd1;
               fetch_in.write_cand = visible;
            end
         end else begin
            row_in    = '0;
            offset_in = '0;
            if ({1'b0, column_ff} + 11'd1 >= {1'b0, scale_width_ff}) begin
               finished_in   = 1'b1;
               fetch_in.done = 1'b1;
            end else begin
               column_in = column_ff + 10'd1;
            end
         end
      end
      fetch_in.error = failed_in;
   end

   sscb_ram #(
      .WIDTH (8),
      .DEPTH (SOURCE_DEPTH)
   ) u_source (
      .clock   (clock),
      .wr_en   (accept && is_load && (loaded_ff != FULL_COUNT)),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (source_byte),
      .rd_en   (accept),
      .rd_addr (sum[AW-1:0]),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         screen_width_ff  <= sscb_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= sscb_pkg::SCREEN_HEIGHT_RESET;
         line_pitch_ff    <= sscb_pkg::LINE_PITCH_RESET;
         transparent_ff   <= '0;
         scale_width_ff   <= sscb_pkg::SCALE_WIDTH_RESET;
         scale_height_ff  <= sscb_pkg::SCALE_HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sscb_pkg::REG_ORIGIN_X:      origin_x_ff      <= csr_data;
            sscb_pkg::REG_ORIGIN_Y:      origin_y_ff      <= csr_data;
            sscb_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_data[11:0];
            sscb_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_data[11:0];
            sscb_pkg::REG_LINE_PITCH:    line_pitch_ff    <= csr_data[11:0];
            sscb_pkg::REG_TRANSPARENT:   transparent_ff   <= csr_data[7:0];
            sscb_pkg::REG_SCALE_WIDTH:   scale_width_ff   <= csr_data[9:0];
            sscb_pkg::REG_SCALE_HEIGHT:  scale_height_ff  <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         offset_ff   <= '0;
         row_ff      <= '0;
         column_ff   <= '0;
         failed_ff   <= 1'b0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         loaded_ff   <= loaded_in;
         offset_ff   <= offset_in;
         row_ff      <= row_in;
         column_ff   <= column_in;
         failed_ff   <= failed_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_valid_ff <= 1'b0;
      end else if (accept) begin
         fetch_valid_ff <= 1'b1;
      end else if (fetch_move) begin
         fetch_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fetch_ff <= fetch_in;
      end
   end

   // pixel stage
   assign product     = fetch_ff.dy * line_pitch_ff;
   assign pixel_write = fetch_ff.write_cand && (ram_data != transparent_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fetch_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_move) begin
         write_ff <= pixel_write;
         addr_ff  <= pixel_write ? (product + {12'd0, fetch_ff.dx}) : 24'd0;
         color_ff <= pixel_write ? ram_data : 8'd0;
         error_ff <= fetch_ff.error;
         done_ff  <= fetch_ff.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = write_ff;
   assign rsp_tdata  = {7'd0, error_ff, color_ff, addr_ff};
   assign rsp_tlast  = done_ff;

endmodule

// ===== verif/sscb_blit_monitor.sv =====
`timescale 1ns / 1ps
// Blit response monitor: tracks requests and register writes, predicts each response, compares.
module sscb_blit_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [0:0]  rsp_tuser,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          pixel_writes,
   output int          frames_done,
   output int          error_responses
);
   import sscb_pkg::*;

   typedef struct packed {
      logic        pixel_write;
      logic [23:0] pixel_address;
      logic [7:0]  pixel_color;
      logic        error;
      logic        frame_done;
   } blit_result_type;

   blit_result_type expected_writes[$];

   // predicted blitter state
   logic [7:0] sprite_bytes [SOURCE_DEPTH];
   int         bytes_loaded;
   longint     src_offset;
   int         row_pos;
   int         col_pos;
   bit         halted_err;
   bit         frame_finished;

   // shadow registers
   logic signed [15:0] cfg_origin_x;
   logic signed [15:0] cfg_origin_y;
   logic [11:0]        cfg_screen_w;
   logic [11:0]        cfg_screen_h;
   logic [11:0]        cfg_pitch;
   logic [7:0]         cfg_transparent;
   logic [9:0]         cfg_scale_w;
   logic [9:0]         cfg_scale_h;

   int mismatches;
   int writes_seen;
   int frames_seen;
   int errors_seen;

   function automatic blit_result_type blit_request(logic [1:0] cmd, logic [31:0] step,
                                                    logic [7:0] src);
      blit_result_type res;
      longint          inc;
      int              dx;
      int              dy;
      logic [7:0]      pix;
      res = '0;
      case (cmd)
         CMD_LOAD: begin
            if (bytes_loaded < SOURCE_DEPTH) begin
               sprite_bytes[bytes_loaded] = src;
               bytes_loaded++;
            end
         end
         CMD_CLEAR: begin
            src_offset     = 0;
            row_pos        = 0;
            col_pos        = 0;
            halted_err     = 0;
            frame_finished = 0;
         end
         CMD_STEP: begin
            if (!halted_err && !frame_finished) begin
               inc = longint'(signed'(step));
               if (cfg_pitch < cfg_screen_w) begin
                  halted_err = 1;
               end else begin
                  src_offset = (row_pos == 0) ? inc : src_offset + inc;
                  if (row_pos < int'(cfg_scale_h)) begin
                     if (src_offset < 0 || src_offset >= longint'(bytes_loaded)) begin
                        halted_err = 1;
                     end else begin
                        pix = sprite_bytes[int'(src_offset)];
                        dx  = int'(cfg_origin_x) + col_pos;
                        dy  = int'(cfg_origin_y) + row_pos;
                        if (pix != cfg_transparent && dx >= 0 && dy >= 0 &&
                            dx < int'(cfg_screen_w) && dy < int'(cfg_screen_h)) begin
                           res.pixel_write   = 1;
                           res.pixel_color   = pix;
                           res.pixel_address = 24'(dy * int'(cfg_pitch) + dx);
                        end
                        row_pos++;
                     end
                  end else begin
                     // trailing increment: close the column
                     row_pos    = 0;
                     src_offset = 0;
                     if (col_pos + 1 >= int'(cfg_scale_w)) begin
                        frame_finished = 1;
                        res.frame_done = 1;
                     end else begin
                        col_pos++;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      res.error = halted_err;
      return res;
   endfunction

   function automatic void report_field(string field_name, logic [31:0] want_v,
                                        logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, field_name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      blit_result_type seen;
      blit_result_type want;
      if (reset) begin
         expected_writes.delete();
         bytes_loaded    = 0;
         src_offset      = 0;
         row_pos         = 0;
         col_pos         = 0;
         halted_err      = 0;
         frame_finished  = 0;
         cfg_origin_x    = '0;
         cfg_origin_y    = '0;
         cfg_screen_w    = SCREEN_WIDTH_RESET;
         cfg_screen_h    = SCREEN_HEIGHT_RESET;
         cfg_pitch       = LINE_PITCH_RESET;
         cfg_transparent = '0;
         cfg_scale_w     = SCALE_WIDTH_RESET;
         cfg_scale_h     = SCALE_HEIGHT_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.pixel_write   = rsp_tuser[0];
            seen.pixel_address = rsp_tdata[23:0];
            seen.pixel_color   = rsp_tdata[31:24];
            seen.error         = rsp_tdata[32];
            seen.frame_done    = rsp_tlast;
            if (expected_writes.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %p",
                        $time, seen);
               mismatches++;
            end else begin
               want = expected_writes.pop_front();
               report_field("pixel_write", 32'(want.pixel_write), 32'(seen.pixel_write));
               report_field("pixel_address", 32'(want.pixel_address),
                            32'(seen.pixel_address));
               report_field("pixel_color", 32'(want.pixel_color), 32'(seen.pixel_color));
               report_field("error", 32'(want.error), 32'(seen.error));
               report_field("frame_done", 32'(want.frame_done), 32'(seen.frame_done));
               if (want.pixel_write) writes_seen++;
               if (want.frame_done) frames_seen++;
               if (want.error) errors_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ORIGIN_X:      cfg_origin_x    = csr_data;
               REG_ORIGIN_Y:      cfg_origin_y    = csr_data;
               REG_SCREEN_WIDTH:  cfg_screen_w    = csr_data[11:0];
               REG_SCREEN_HEIGHT: cfg_screen_h    = csr_data[11:0];
               REG_LINE_PITCH:    cfg_pitch       = csr_data[11:0];
               REG_TRANSPARENT:   cfg_transparent = csr_data[7:0];
               REG_SCALE_WIDTH:   cfg_scale_w     = csr_data[9:0];
               REG_SCALE_HEIGHT:  cfg_scale_h     = csr_data[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_writes.push_back(blit_request(req_tuser, req_tdata[31:0],
                                                   req_tdata[39:32]));
         end
      end
      fail_count      <= mismatches;
      pending         <= expected_writes.size();
      pixel_writes    <= writes_seen;
      frames_done     <= frames_seen;
      error_responses <= errors_seen;
   end

endmodule

// ===== verif/tb_scaled_sprite_column_blit.sv =====
`timescale 1ns / 1ps
// Testbench top: drives sprite blitter requests and register writes, reports the verdict.
module tb_scaled_sprite_column_blit;
   import sscb_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;

   // command value with no meaning to the block
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [0:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int fail_count;
   int pending;
   int pixel_writes;
   int frames_done;
   int error_responses;

   int gap_pct;
   int stall_pct;
   int cycle_count;
   int loaded_bytes;
   int cur_scale_w;
   int cur_scale_h;
   int n_load;
   int n_step;
   int n_clear;
   int n_unused;

   scaled_sprite_column_blit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sscb_blit_monitor blit_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .pixel_writes    (pixel_writes),
      .frames_done     (frames_done),
      .error_responses (error_responses)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // holds the request until accepted; a random gap may come first
   task automatic send_request(input logic [1:0] cmd, input logic [31:0] step,
                               input logic [7:0] src);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {src, step};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (cmd)
         CMD_LOAD: begin
            n_load++;
            if (loaded_bytes < SOURCE_DEPTH) loaded_bytes++;
         end
         CMD_STEP:  n_step++;
         CMD_CLEAR: n_clear++;
         default:   n_unused++;
      endcase
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // every request answers, so idle means nothing left outstanding
   task automatic settle();
      req_tvalid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_bytes(input int count);
      logic [7:0] palette [5];
      int i;
      palette = '{8'h00, 8'hA5, 8'hFF, 8'h11, 8'h03};
      for (i = 0; i < count; i++)
         send_request(CMD_LOAD, $urandom,
                      $urandom_range(1) ? 8'($urandom) : palette[$urandom_range(4)]);
   endtask

   // mostly well-formed frames (clear, then scale_h+1 increments per column) with noise
   task automatic draw_frames(input int count);
      int          sent;
      int          col;
      int          row;
      int          cols;
      int          pick;
      longint      at;
      longint      target;
      logic [31:0] step_v;
      sent = 0;
      while (sent < count) begin
         send_request(CMD_CLEAR, $urandom, 8'($urandom));
         sent++;
         cols = (cur_scale_w == 0) ? 1 : cur_scale_w;
         for (col = 0; col < cols && sent < count; col++) begin
            at = 0;
            for (row = 0; row <= cur_scale_h && sent < count; row++) begin
               pick = $urandom_range(99);
               if (pick < 5) begin
                  case ($urandom_range(3))
                     0: send_request(CMD_LOAD, $urandom, 8'($urandom));
                     1: send_request(CMD_UNKNOWN, $urandom, 8'($urandom));
                     2: send_request(CMD_STEP, $urandom, 8'($urandom));
                     default: send_request(CMD_CLEAR, $urandom, 8'($urandom));
                  endcase
                  sent++;
               end
               if (row == cur_scale_h) begin
                  // trailing increment only closes the column, its value is unused, any value goes
                  step_v = $urandom;
               end else begin
                  if (pick >= 5 && pick < 8)
                     target = $urandom_range(1)
                              ? longint'(loaded_bytes) + longint'($urandom_range(2))
                              : -1 - longint'($urandom_range(2));
                  else
                     target = longint'($urandom_range(loaded_bytes - 1));
                  step_v = 32'(target - at);
                  at     = target;
               end
               send_request(CMD_STEP, step_v, 8'($urandom));
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] sw, input logic [15:0] sh,
                            input logic [15:0] lp, input logic [15:0] tc,
                            input logic [15:0] scw, input logic [15:0] sch,
                            input int count, input int mode);
      settle();
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_SCREEN_WIDTH, sw);
      write_reg(REG_SCREEN_HEIGHT, sh);
      write_reg(REG_LINE_PITCH, lp);
      write_reg(REG_TRANSPARENT, tc);
      write_reg(REG_SCALE_WIDTH, scw);
      write_reg(REG_SCALE_HEIGHT, sch);
      csr_valid   <= 0;
      cur_scale_w = int'(scw[9:0]);
      cur_scale_h = int'(sch[9:0]);
      case (mode)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 51; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 51; end
         default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      // no clear first: a column left open by the last phase meets the new scale
      repeat (2) send_request(CMD_STEP, $urandom_range(loaded_bytes - 1), 8'($urandom));
      draw_frames(count);
   endtask

   initial begin
      reset        = 1;
      req_tvalid   = 0;
      req_tuser    = CMD_LOAD;
      req_tdata    = '0;
      rsp_tready   = 0;
      csr_valid    = 0;
      csr_index    = REG_ORIGIN_X;
      csr_data     = '0;
      gap_pct      = 0;
      stall_pct    = 0;
      cycle_count  = 0;
      loaded_bytes = 0;
      cur_scale_w  = 1;
      cur_scale_h  = 1;
      n_load       = 0;
      n_step       = 0;
      n_clear      = 0;
      n_unused     = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, 1x1 sprite, transparent 0
      send_request(CMD_LOAD, 32'h0, 8'h00);
      send_request(CMD_LOAD, 32'h0, 8'hFF);
      send_request(CMD_LOAD, 32'h0, 8'hA5);
      send_request(CMD_LOAD, 32'h0, 8'h5A);
      send_request(CMD_LOAD, 32'h0, 8'h01);
      send_request(CMD_LOAD, 32'h0, 8'h80);
      send_request(CMD_LOAD, 32'h0, 8'h7F);
      send_request(CMD_LOAD, 32'hFFFF_FFFF, 8'h11);
      send_request(CMD_UNKNOWN, 32'hFFFF_FFFF, 8'hFF);
      send_request(CMD_STEP, 32'd1, 8'h00);           // opaque pixel at the origin
      send_request(CMD_STEP, 32'h7FFF_FFFF, 8'h00);   // final increment ends the frame
      send_request(CMD_STEP, 32'd5, 8'h00);           // finished: ignored
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'd0, 8'h00);           // transparent source
      send_request(CMD_STEP, 32'h8000_0000, 8'h00);
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'hFFFF_FFFF, 8'h00);   // negative offset
      send_request(CMD_STEP, 32'd3, 8'h00);           // stays failed
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'd8, 8'h00);           // one past the loaded bytes
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'd7, 8'h00);           // last loaded byte
      send_request(CMD_STEP, 32'd0, 8'h00);
      send_request(CMD_CLEAR, 32'h0, 8'h00);

      load_bytes(40);

      run_phase(16'd0, 16'd0, 16'd320, 16'd200, 16'd320, 16'h00, 16'd3, 16'd4, 100, 0);
      run_phase(-16'sd2, -16'sd3, 16'd16, 16'd12, 16'd16, 16'hA5, 16'd5, 16'd6, 100, 1);
      run_phase(16'd310, 16'd195, 16'd320, 16'd200, 16'd400, 16'hFF, 16'd8, 16'd7, 100, 2);
      run_phase(16'd5, 16'd5, 16'd64, 16'd64, 16'd64, 16'h03, 16'd1023, 16'd1023, 30, 3);
      run_phase(16'h7FFF, 16'h8000, 16'd4095, 16'd4095, 16'd4095, 16'h00, 16'd2, 16'd3, 90,
                0);
      run_phase(16'd4090, 16'd4090, 16'd4095, 16'd4095, 16'd4095, 16'h11, 16'd6, 16'd6, 100,
                1);
      run_phase(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'h00, 16'd1, 16'd0, 90, 2);
      // pitch narrower than the screen: every step fails
      run_phase(16'd0, 16'd0, 16'd100, 16'd50, 16'd99, 16'hA5, 16'd2, 16'd2, 30, 3);
      run_phase(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'hFF, 16'd0, 16'd2, 60, 0);

      // offsets at the edge of the loaded bytes
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'(loaded_bytes - 1), 8'h00);
      send_request(CMD_CLEAR, 32'h0, 8'h00);
      send_request(CMD_STEP, 32'(loaded_bytes), 8'h00);

      settle();
      $display("covered %0d loads, %0d steps, %0d clears, %0d unused-code requests, %0d cycles",
               n_load, n_step, n_clear, n_unused, cycle_count);
      $display("%0d pixel writes, %0d finished frames, %0d responses flagged in error",
               pixel_writes, frames_done, error_responses);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sscb_pkg.sv
rtl/sscb_ram.sv
rtl/scaled_sprite_column_blit.sv
verif/sscb_blit_monitor.sv
verif/tb_scaled_sprite_column_blit.sv
